[src/xsr_pkg.sv]
// shared types, codes and constants for the xorshift64 range generator
// no dependencies; used by xsr_mul and xorshift64_random_with_range_core
package xsr_pkg;

  typedef logic [31:0] word_t;
  typedef logic [63:0] dword_t;

  // operation codes carried on tuser
  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_MERGE = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;

  localparam word_t  MIX_MULT    = 32'd2466808117;
  localparam word_t  FNV_PRIME   = 32'd16777619;
  localparam dword_t STATE_RESET = 64'h1234_5678_9abc_def0;

  localparam int unsigned XS_A = 12;
  localparam int unsigned XS_B = 25;
  localparam int unsigned XS_C = 27;

  // one xorshift step, a zero state is first forced to one
  function automatic dword_t xorshift64(input dword_t s);
    dword_t r;
    r = (s == '0) ? 64'd1 : s;
    r = r ^ (r >> XS_A);
    r = r ^ (r << XS_B);
    r = r ^ (r >> XS_C);
    return r;
  endfunction

endpackage

[src/xsr_mul.sv]
// shared 32x32 unsigned multiplier with registered 64-bit product
// depends on xsr_pkg for word types
module xsr_mul (
  input  logic           clk,
  input  xsr_pkg::word_t a,
  input  xsr_pkg::word_t b,
  output xsr_pkg::dword_t prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

[src/xorshift64_random_with_range_core.sv]
// xorshift64 generator with range mapping, entropy merge and seed load
// depends on xsr_pkg and the shared multiplier xsr_mul
//
// The block keeps a 64-bit generator state and takes one item at a time. A
// draw with a non-empty range runs one xorshift step, then three passes
// through the single registered 32x32 multiplier for the two mixing products
// and the multiply-high range map, then the output stage; a full-range draw
// skips the last multiplier pass, and a draw whose low and high are equal
// goes straight to the output stage. A merge takes one multiplier pass, a
// load is done in the idle state, and func 3 is dropped there. Results
// sit in an output register, so a draw only waits on the master side when an
// earlier result has not yet been taken.
module xorshift64_random_with_range_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // range_low [31:0], range_high [63:32], data_byte [71:64], seed_value [135:72]
  input  logic [135:0] s_tdata,
  input  logic         s_tlast,   // last_byte
  input  logic [1:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata    // value [31:0]
);

  typedef enum logic [2:0] {
    S_IDLE, S_ADV, S_P1, S_P2, S_MAP, S_FIN, S_OUT, S_MFIN
  } fsm_t;

  fsm_t fsm;
  xsr_pkg::dword_t gen_state;
  xsr_pkg::word_t  low_r, n_r, mix_r, res_r;
  logic [7:0]      byte_r;
  logic            last_r;

  xsr_pkg::word_t  mul_a, mul_b, mix_c;
  xsr_pkg::dword_t prod, merged;
  logic            in_xfer, out_free;

  assign s_tready = (fsm == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign mix_c    = mix_r ^ prod[31:0];
  assign merged   = gen_state ^ prod;

  // operand selection for the shared multiplier
  always_comb begin
    case (fsm)
      S_P1: begin
        mul_a = gen_state[63:32];
        mul_b = gen_state[31:0];
      end
      S_P2: begin
        mul_a = ~gen_state[47:16];
        mul_b = xsr_pkg::MIX_MULT;
      end
      S_MAP: begin
        mul_a = mix_c;
        mul_b = n_r;
      end
      default: begin
        // idle slot is used to start a merge product
        mul_a = gen_state[31:0] ^ {24'd0, s_tdata[71:64]};
        mul_b = xsr_pkg::FNV_PRIME;
      end
    endcase
  end

  xsr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      gen_state <= xsr_pkg::STATE_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      // the output step sets valid itself
      if (m_tready && fsm != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (in_xfer) begin
            low_r  <= s_tdata[31:0];
            n_r    <= s_tdata[63:32] - s_tdata[31:0] + 32'd1;
            byte_r <= s_tdata[71:64];
            last_r <= s_tlast;
            case (s_tuser)
              xsr_pkg::FUNC_DRAW: begin
                if (s_tdata[63:32] == s_tdata[31:0]) begin
                  res_r <= s_tdata[31:0];
                  fsm   <= S_OUT;
                end else begin
                  fsm <= S_ADV;
                end
              end
              xsr_pkg::FUNC_MERGE: begin
                fsm <= S_MFIN;
              end
              xsr_pkg::FUNC_LOAD: begin
                gen_state <= (s_tdata[135:72] == '0) ? 64'd1 : s_tdata[135:72];
              end
              default: begin
              end
            endcase
          end
        end
        S_ADV: begin
          gen_state <= xsr_pkg::xorshift64(gen_state);
          fsm       <= S_P1;
        end
        S_P1: begin
          fsm <= S_P2;
        end
        S_P2: begin
          mix_r <= prod[31:0];
          fsm   <= S_MAP;
        end
        S_MAP: begin
          if (n_r == '0) begin
            // full range, mixed word is the offset itself
            res_r <= low_r + mix_c;
            fsm   <= S_OUT;
          end else begin
            fsm <= S_FIN;
          end
        end
        S_FIN: begin
          res_r <= low_r + prod[63:32];
          fsm   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tdata  <= res_r;
            m_tvalid <= 1'b1;
            fsm      <= S_IDLE;
          end
        end
        S_MFIN: begin
          gen_state <= (last_r && merged == '0) ? 64'd1 : merged;
          fsm       <= S_IDLE;
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  a_load_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_xfer && s_tuser == xsr_pkg::FUNC_LOAD |=> gen_state != '0)
    else $error("load left a zero generator state");

  a_adv_nonzero: assert property (@(posedge clk) disable iff (rst)
    fsm == S_ADV |=> gen_state != '0)
    else $error("xorshift step produced a zero state");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fsm) == S_OUT)
    else $error("result presented outside the output step");

  a_merge_byte: assert property (@(posedge clk) disable iff (rst)
    fsm == S_MFIN |-> $past(mul_a[7:0]) == (byte_r ^ $past(gen_state[7:0])))
    else $error("merge product started with the wrong byte");

endmodule
